// ===== rtl/nibble_run_sequence_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// nibble run sequence decoder - assertion macros
// shared concurrent assertion forms used by the decoder modules
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RUN_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define NIBBLE_RUN_SEQUENCE_DECODER_UNIT_MACROS_SVH

// condition holds whenever reset is low
`define NRSD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NRSD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NRSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nrsd_pkg.sv =====
// ----------------------------------------------------------------------------
// nrsd_pkg
// shared types and constants of the nibble run sequence decoder
// ----------------------------------------------------------------------------
package nrsd_pkg;

  localparam int INDEX_WIDTH    = 16;
  localparam int FIELD_WIDTH    = 16;
  localparam int COUNT_WIDTH    = 17;
  localparam int SHIFT_WIDTH    = 6;
  localparam int SHIFT_LIMIT    = 63;
  localparam int NIBBLE_STEP    = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = 2;
  localparam int QUEUE_CW       = 3;
  localparam int OUT_DATA_WIDTH = 56;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_RANGE      = 2'd1,
    STATUS_UNFINISHED = 2'd2,
    STATUS_TOO_LONG   = 2'd3
  } status_t;

  typedef enum logic {
    KIND_RUN     = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // one decoded byte: an optional run descriptor and an optional summary
  typedef struct packed {
    logic                   has_run;
    logic                   has_sum;
    logic [FIELD_WIDTH-1:0] start;
    logic [FIELD_WIDTH-1:0] length;
    logic [FIELD_WIDTH-1:0] total;
    status_t                status;
  } job_t;

endpackage

// ===== rtl/nrsd_front.sv =====
// ----------------------------------------------------------------------------
// nrsd_front
// accepts sequence bytes, decodes both nibbles combinationally, queues results
// ----------------------------------------------------------------------------
module nrsd_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               in_final,
  input  logic [nrsd_pkg::FIELD_WIDTH-1:0]   file_count,
  output logic                               push,
  output nrsd_pkg::job_t                     push_job,
  input  logic                               full
);

  localparam int PW  = nrsd_pkg::INDEX_WIDTH + 1;
  localparam int VW  = VALUE_WIDTH;
  localparam int CW  = nrsd_pkg::COUNT_WIDTH;
  localparam int SW  = nrsd_pkg::SHIFT_WIDTH;
  localparam int FW  = nrsd_pkg::FIELD_WIDTH;
  localparam int MW0 = (VW > PW) ? VW : PW;
  localparam int MW1 = (MW0 > CW) ? MW0 : CW;
  localparam int EW  = MW1 + 1;
  localparam logic [PW-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [VW-1:0]     acc;
    logic [SW-1:0]     shift;
    logic              jump;
    logic              phase;
    logic [PW-1:0]     pos;
    logic [CW-1:0]     cnt;
    nrsd_pkg::status_t err;
  } dec_t;

  typedef struct packed {
    dec_t          st;
    logic          run;
    logic [PW-1:0] start;
    logic [VW-1:0] len;
  } step_t;

  // idle decode state, next value is a run
  localparam dec_t DEC_CLEAR = '{
    acc:   '0,
    shift: '0,
    jump:  1'b0,
    phase: 1'b1,
    pos:   '0,
    cnt:   '0,
    err:   nrsd_pkg::STATUS_OK
  };

  function automatic step_t nib_step(input dec_t cur, input logic [3:0] nib,
                                     input logic [FW-1:0] fc);
    step_t         r;
    logic [2:0]    d;
    logic          ovf;
    logic [SW:0]   s3;
    logic [VW-1:0] acc_n;
    logic [VW-1:0] v;
    logic [EW-1:0] pos_sum;
    logic [EW-1:0] cnt_sum;
    logic          in_range;
    r       = '0;
    r.st    = cur;
    r.start = cur.pos;
    d       = nib[2:0];
    ovf     = 1'b0;
    for (int i = 0; i < nrsd_pkg::NIBBLE_STEP; i++) begin
      if (d[i] && (int'(cur.shift) + i >= VW)) begin
        ovf = 1'b1;
      end
    end
    s3       = {1'b0, cur.shift} + (SW+1)'(nrsd_pkg::NIBBLE_STEP);
    acc_n    = cur.acc | (VW'(d) << cur.shift);
    v        = acc_n;
    pos_sum  = EW'(cur.pos) + EW'(v);
    cnt_sum  = EW'(cur.cnt) + EW'(v);
    in_range = (EW'(v) <= EW'(fc)) && (pos_sum <= EW'(fc)) && (cnt_sum <= EW'(fc));
    if (cur.err != nrsd_pkg::STATUS_OK) begin
      r.st = cur;
    end else if (ovf) begin
      r.st.err = nrsd_pkg::STATUS_TOO_LONG;
    end else if (nib[3]) begin
      r.st.acc = acc_n;
      if (s3 > (SW+1)'(nrsd_pkg::SHIFT_LIMIT)) begin
        r.st.err = nrsd_pkg::STATUS_TOO_LONG;
      end else begin
        r.st.shift = s3[SW-1:0];
      end
    end else begin
      r.st.acc   = '0;
      r.st.shift = '0;
      if (cur.jump) begin
        // absolute position, saturated past any file count
        r.st.jump  = 1'b0;
        r.st.phase = 1'b1;
        r.st.pos   = (EW'(v) > EW'(POS_MAX)) ? POS_MAX : PW'(v);
      end else if (v == '0) begin
        r.st.jump = 1'b1;
      end else if (!cur.phase) begin
        r.st.phase = 1'b1;
        r.st.pos   = (pos_sum > EW'(POS_MAX)) ? POS_MAX : pos_sum[PW-1:0];
      end else if (!in_range) begin
        r.st.err = nrsd_pkg::STATUS_RANGE;
      end else begin
        r.run      = 1'b1;
        r.len      = v;
        r.st.pos   = pos_sum[PW-1:0];
        r.st.cnt   = cnt_sum[CW-1:0];
        r.st.phase = 1'b0;
      end
    end
    return r;
  endfunction

  dec_t  state;
  dec_t  state_next;
  step_t hi_step;
  step_t lo_step;
  logic  accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hi_step = nib_step(state, in_byte[7:4], file_count);
    lo_step = nib_step(hi_step.st, in_byte[3:0], file_count);

    // at most one run can finish per byte
    push_job.has_run = hi_step.run || lo_step.run;
    push_job.has_sum = in_final;
    push_job.start   = hi_step.run ? FW'(hi_step.start) : FW'(lo_step.start);
    push_job.length  = hi_step.run ? FW'(hi_step.len) : FW'(lo_step.len);
    push_job.total   = FW'(lo_step.st.cnt);
    if (lo_step.st.err != nrsd_pkg::STATUS_OK) begin
      push_job.status = lo_step.st.err;
    end else if (lo_step.st.shift != '0) begin
      push_job.status = nrsd_pkg::STATUS_UNFINISHED;
    end else begin
      push_job.status = nrsd_pkg::STATUS_OK;
    end

    push = accept && (push_job.has_run || push_job.has_sum);

    state_next = state;
    if (accept) begin
      if (in_final) begin
        state_next = DEC_CLEAR;
      end else begin
        state_next = lo_step.st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DEC_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `include "nibble_run_sequence_decoder_unit_macros.svh"

  `NRSD_ASSERT_NEXT(a_err_sticky, clk, rst,
    (state.err != nrsd_pkg::STATUS_OK) && !(accept && in_final),
    state.err == $past(state.err), "error code changed before end of sequence")
  `NRSD_ASSERT_IMPLIES(a_no_push_when_full, clk, rst, push, !full,
    "word pushed into full queue")

endmodule

// ===== rtl/nrsd_queue.sv =====
// ----------------------------------------------------------------------------
// nrsd_queue
// short register queue between the byte decoder and the result sequencer
// ----------------------------------------------------------------------------
module nrsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nrsd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output nrsd_pkg::job_t head,
  output logic           empty
);

  nrsd_pkg::job_t                 entries [nrsd_pkg::QUEUE_DEPTH];
  logic [nrsd_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [nrsd_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [nrsd_pkg::QUEUE_CW-1:0]  count;

  assign full  = (count == nrsd_pkg::QUEUE_CW'(nrsd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `include "nibble_run_sequence_decoder_unit_macros.svh"

  `NRSD_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst, pop, !empty,
    "word popped from empty queue")
  `NRSD_ASSERT_ALWAYS(a_count_bound, clk, rst,
    count <= nrsd_pkg::QUEUE_CW'(nrsd_pkg::QUEUE_DEPTH), "queue count overrun")

endmodule

// ===== rtl/nrsd_back.sv =====
// ----------------------------------------------------------------------------
// nrsd_back
// turns queued byte results into run and summary words on the output
// ----------------------------------------------------------------------------
module nrsd_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nrsd_pkg::job_t                        head,
  input  logic                                  empty,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [nrsd_pkg::OUT_DATA_WIDTH-1:0]   out_data,
  output nrsd_pkg::kind_t                       out_kind,
  output logic                                  out_last
);

  localparam int FW  = nrsd_pkg::FIELD_WIDTH;
  localparam int PAD = nrsd_pkg::OUT_DATA_WIDTH - 3 * FW - 2;

  logic                  load_ok;
  logic                  sum_pend;
  logic [FW-1:0]         sum_total;
  nrsd_pkg::status_t     sum_status;

  assign load_ok = !out_valid || out_ready;
  assign pop     = load_ok && !sum_pend && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum_pend  <= 1'b0;
    end else if (load_ok) begin
      if (sum_pend) begin
        out_valid <= 1'b1;
        sum_pend  <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        sum_pend  <= head.has_run && head.has_sum;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (sum_pend) begin
        out_kind <= nrsd_pkg::KIND_SUMMARY;
        out_data <= {PAD'(0), sum_status, sum_total, FW'(0), FW'(0)};
        out_last <= 1'b1;
      end else if (!empty) begin
        if (head.has_run) begin
          out_kind <= nrsd_pkg::KIND_RUN;
          out_data <= {PAD'(0), nrsd_pkg::STATUS_OK, head.total, head.length, head.start};
          out_last <= !head.has_sum;
        end else begin
          out_kind <= nrsd_pkg::KIND_SUMMARY;
          out_data <= {PAD'(0), head.status, head.total, FW'(0), FW'(0)};
          out_last <= 1'b1;
        end
        // summary after a run word waits here
        sum_total  <= head.total;
        sum_status <= head.status;
      end
    end
  end

  `include "nibble_run_sequence_decoder_unit_macros.svh"

  `NRSD_ASSERT_IMPLIES(a_sum_behind_run, clk, rst, sum_pend,
    out_valid && !out_last && (out_kind == nrsd_pkg::KIND_RUN),
    "pending summary without a run word in front of it")

endmodule

// ===== rtl/nibble_run_sequence_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// nibble_run_sequence_decoder_unit
// decodes packed nibble index sequences into run descriptors and a summary
// ----------------------------------------------------------------------------
// usage:
//   s_axis: one sequence byte per word in tdata[7:0], high nibble decoded
//   first; tlast marks the last byte of a sequence.
//   m_axis: run descriptor (tuser = 0) or end-of-sequence summary (tuser = 1);
//   tlast marks the last word caused by one input byte.
//   cfg: file_count write, taken in any cycle; write it only while idle.
// throughput: one byte per cycle while the queue is not full; the decoder holds
//   both nibble steps combinationally. a final byte that also finishes a run
//   gives two words, which leave the output register one after the other.
// each result word is registered in a queue entry and then in the output register.
// a four-entry queue sits between decoder and output, so s_axis_tready only
//   drops when that queue is full, because m_axis is stalled or because
//   two-word final bytes come faster than the output register drains them.
// reset clears the decode state and file_count; the output goes idle.
// ----------------------------------------------------------------------------
module nibble_run_sequence_decoder_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,   // seq_byte
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // run_start [15:0], run_length [31:16], total_indices [47:32], status [49:48]
  output logic [nrsd_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata,
  output logic                                  m_axis_tuser,   // kind
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nrsd_pkg::FIELD_WIDTH-1:0]      cfg_data
);

  logic [nrsd_pkg::FIELD_WIDTH-1:0] file_count;
  logic                             push;
  nrsd_pkg::job_t                   push_job;
  logic                             full;
  logic                             pop;
  nrsd_pkg::job_t                   head;
  logic                             empty;
  nrsd_pkg::kind_t                  out_kind;

  assign cfg_ready    = 1'b1;
  assign m_axis_tuser = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_count <= cfg_data;
    end
  end

  nrsd_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_final   (s_axis_tlast),
    .file_count (file_count),
    .push       (push),
    .push_job   (push_job),
    .full       (full)
  );

  nrsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  nrsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (out_kind),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== tb/sv/nibble_run_sequence_decoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nibble_run_sequence_decoder_unit_test
// self-checking bench: a short table of directed bytes, then random sequences
// under several file counts. every accepted byte is run through a local
// decoder model and each output word is compared field by field, in order.
// ----------------------------------------------------------------------------
module nibble_run_sequence_decoder_unit_test;

  localparam int FW = nrsd_pkg::FIELD_WIDTH;
  localparam int VALUE_BITS = 32;
  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 1;
  localparam logic [63:0] POS_LIMIT = (64'd1 << (nrsd_pkg::INDEX_WIDTH + 1)) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 300;
  localparam int NUM_PHASES = 6;
  localparam logic [FW-1:0] FILES_MAX = '1;

  typedef struct packed {
    nrsd_pkg::kind_t   kind;
    logic [FW-1:0]     start;
    logic [FW-1:0]     length;
    logic [FW-1:0]     total;
    nrsd_pkg::status_t status;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } seq_item_t;

  // ntyped = 0: words come from the decoder model, else w0/w1 as written
  typedef struct packed {
    logic      set_max;
    seq_item_t item;
    logic [1:0] ntyped;
    out_word_t w0;
    out_word_t w1;
  } dir_row_t;

  localparam out_word_t NO_WORD = '0;
  localparam int NUM_ROWS = 25;

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // run against the reset file count of zero
    '{1'b0, '{8'h10, 1'b1}, 2'd1,
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'd0, nrsd_pkg::STATUS_RANGE, 1'b1},
      NO_WORD},
    // run, skip, jump, run, skip, run
    '{1'b1, '{8'h12, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h00, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hF7, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h31, 1'b1}, 2'd0, NO_WORD, NO_WORD},
    // set bit lands past the value width
    '{1'b0, '{8'h88, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h88, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h88, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h88, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h88, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h88, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h10, 1'b1}, 2'd1,
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'd0, nrsd_pkg::STATUS_TOO_LONG, 1'b1},
      NO_WORD},
    // ends inside a value
    '{1'b0, '{8'h08, 1'b1}, 2'd1,
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'd0, nrsd_pkg::STATUS_UNFINISHED, 1'b1},
      NO_WORD},
    // jump to the largest value, position saturates, run then out of range
    '{1'b0, '{8'h0F, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hFF, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hFF, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hFF, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hFF, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hF3, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'h10, 1'b1}, 2'd1,
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'd0, nrsd_pkg::STATUS_RANGE, 1'b1},
      NO_WORD},
    // one run filling the whole file count, plus summary on the same byte
    '{1'b0, '{8'hFF, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hFF, 1'b0}, 2'd0, NO_WORD, NO_WORD},
    '{1'b0, '{8'hF1, 1'b1}, 2'd2,
      '{nrsd_pkg::KIND_RUN, 16'd0, 16'hFFFF, 16'hFFFF, nrsd_pkg::STATUS_OK, 1'b0},
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'hFFFF, nrsd_pkg::STATUS_OK, 1'b1}},
    '{1'b0, '{8'h00, 1'b1}, 2'd1,
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'd0, nrsd_pkg::STATUS_OK, 1'b1},
      NO_WORD},
    '{1'b0, '{8'hFF, 1'b1}, 2'd1,
      '{nrsd_pkg::KIND_SUMMARY, 16'd0, 16'd0, 16'd0, nrsd_pkg::STATUS_UNFINISHED, 1'b1},
      NO_WORD}
  };

  logic                                clk;
  logic                                rst;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [7:0]                          s_axis_tdata;
  logic                                s_axis_tlast;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [nrsd_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata;
  logic                                m_axis_tuser;
  logic                                m_axis_tlast;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [FW-1:0]                       cfg_data;

  nibble_run_sequence_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // decoder model state
  logic [63:0]       acc_value;
  int                acc_shift;
  logic              jump_armed;
  logic              run_next;
  logic [63:0]       cur_pos;
  logic [63:0]       run_total;
  nrsd_pkg::status_t err_status;
  logic [63:0]       files_avail;

  out_word_t   pending_words[$];
  seq_item_t   byte_plan[$];
  int          err_count;
  int          word_count;
  int          cycle_count;
  logic        tx_idle;
  logic        rx_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_decoder();
    acc_value  = '0;
    acc_shift  = 0;
    jump_armed = 1'b0;
    run_next   = 1'b1;
    cur_pos    = '0;
    run_total  = '0;
    err_status = nrsd_pkg::STATUS_OK;
  endfunction

  // one nibble step; returns 1 when a run descriptor comes out
  function automatic logic decode_nibble(input logic [3:0] nib,
                                         output logic [FW-1:0] rs,
                                         output logic [FW-1:0] rl);
    logic [63:0] d;
    logic [63:0] v;
    int          s;
    logic        ovf;
    d  = 64'(nib[2:0]);
    s  = acc_shift;
    rs = '0;
    rl = '0;
    if (err_status != nrsd_pkg::STATUS_OK) return 1'b0;
    if (s >= VALUE_BITS) ovf = (d != 0);
    else if (VALUE_BITS - s < nrsd_pkg::NIBBLE_STEP) ovf = ((d >> (VALUE_BITS - s)) != 0);
    else ovf = 1'b0;
    if (ovf) begin
      err_status = nrsd_pkg::STATUS_TOO_LONG;
      return 1'b0;
    end
    if (s < VALUE_BITS) acc_value = (acc_value | (d << s)) & VALUE_MASK;
    if (nib[3]) begin
      if (s + nrsd_pkg::NIBBLE_STEP > nrsd_pkg::SHIFT_LIMIT) begin
        err_status = nrsd_pkg::STATUS_TOO_LONG;
        return 1'b0;
      end
      acc_shift = s + nrsd_pkg::NIBBLE_STEP;
      return 1'b0;
    end
    v = acc_value;
    acc_value = '0;
    acc_shift = 0;
    if (jump_armed) begin
      jump_armed = 1'b0;
      cur_pos = (v > POS_LIMIT) ? POS_LIMIT : v;
      run_next = 1'b1;
      return 1'b0;
    end
    if (v == 0) begin
      jump_armed = 1'b1;
      return 1'b0;
    end
    if (!run_next) begin
      cur_pos = (v > POS_LIMIT - cur_pos) ? POS_LIMIT : cur_pos + v;
      run_next = 1'b1;
      return 1'b0;
    end
    if (v > files_avail || cur_pos > files_avail - v ||
        run_total > files_avail || v > files_avail - run_total) begin
      err_status = nrsd_pkg::STATUS_RANGE;
      return 1'b0;
    end
    rs = cur_pos[FW-1:0];
    rl = v[FW-1:0];
    cur_pos   = cur_pos + v;
    run_total = run_total + v;
    run_next  = 1'b0;
    return 1'b1;
  endfunction

  // model one accepted byte; keep = 0 only advances the state
  function automatic void predict_byte(input seq_item_t it, input logic keep);
    out_word_t         words[$];
    out_word_t         w;
    logic [FW-1:0]     rs;
    logic [FW-1:0]     rl;
    nrsd_pkg::status_t st;
    if (decode_nibble(it.data[7:4], rs, rl)) begin
      w = '{nrsd_pkg::KIND_RUN, rs, rl, run_total[FW-1:0], nrsd_pkg::STATUS_OK, 1'b0};
      words.push_back(w);
    end
    if (decode_nibble(it.data[3:0], rs, rl)) begin
      w = '{nrsd_pkg::KIND_RUN, rs, rl, run_total[FW-1:0], nrsd_pkg::STATUS_OK, 1'b0};
      words.push_back(w);
    end
    if (it.fin) begin
      st = err_status;
      if (st == nrsd_pkg::STATUS_OK && acc_shift != 0) st = nrsd_pkg::STATUS_UNFINISHED;
      w = '{nrsd_pkg::KIND_SUMMARY, '0, '0, run_total[FW-1:0], st, 1'b0};
      words.push_back(w);
      clear_decoder();
    end
    if (words.size() > 0) words[words.size()-1].last = 1'b1;
    if (keep) foreach (words[i]) pending_words.push_back(words[i]);
  endfunction

  // split a value into 3-bit groups, low group first
  function automatic void add_value(ref logic [3:0] nibs[$], input logic [31:0] v);
    logic [2:0] g;
    do begin
      g = v[2:0];
      v = v >> nrsd_pkg::NIBBLE_STEP;
      nibs.push_back({(v != 0), g});
    end while (v != 0);
  endfunction

  function automatic void plan_sequence();
    logic [3:0] nibs[$];
    seq_item_t  it;
    int         r;
    int         n;
    int         pick;
    logic [31:0] v;
    logic       noisy;
    r = $urandom_range(0, 99);
    noisy = 1'b0;
    if (r < 80) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) v = 0;
        else if (pick < 65) v = $urandom_range(1, 8);
        else if (pick < 82) v = $urandom_range(1, 64);
        else if (pick < 92) v = $urandom_range(1, 65535);
        else if (pick < 97) v = $urandom;
        else v = $urandom_range(131000, 140000);
        add_value(nibs, v);
      end
    end else if (r < 88) begin
      noisy = 1'b1;
      n = $urandom_range(1, 8);
      repeat (2 * n) nibs.push_back(4'($urandom));
    end else if (r < 94) begin
      // long continuation, mostly zero digits, to hit the shift limit
      n = $urandom_range(10, 24);
      repeat (n) nibs.push_back({1'b1, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0});
      nibs.push_back(4'($urandom_range(0, 7)));
    end else begin
      // jump to a value whose top group sits at the value width edge
      nibs.push_back(4'd0);
      repeat (10) nibs.push_back(4'hF);
      nibs.push_back({1'b0, 3'($urandom)});
      add_value(nibs, 1);
    end
    if (nibs.size() % 2) nibs.push_back(4'($urandom));
    for (int i = 0; i < nibs.size(); i += 2) begin
      it.data = {nibs[i], nibs[i+1]};
      it.fin  = (i + 2 >= nibs.size()) || (noisy && $urandom_range(0, 5) == 0);
      byte_plan.push_back(it);
    end
  endfunction

  task automatic send_item(input seq_item_t it);
    int gap;
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = it.data;
    s_axis_tlast  = it.fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold off until every word is out, then write the file count
  task automatic set_file_count(input logic [FW-1:0] v);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    files_avail = 64'(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("word %0d: %s got %0h want %0h", word_count, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, tdata", m_axis_tdata, 0);
      end else begin
        w = pending_words.pop_front();
        if (m_axis_tuser !== w.kind) report_mismatch("kind", m_axis_tuser, w.kind);
        if (m_axis_tdata[15:0] !== w.start)
          report_mismatch("run_start", m_axis_tdata[15:0], w.start);
        if (m_axis_tdata[31:16] !== w.length)
          report_mismatch("run_length", m_axis_tdata[31:16], w.length);
        if (m_axis_tdata[47:32] !== w.total)
          report_mismatch("total_indices", m_axis_tdata[47:32], w.total);
        if (m_axis_tdata[49:48] !== w.status)
          report_mismatch("status", m_axis_tdata[49:48], w.status);
        if (m_axis_tlast !== w.last) report_mismatch("last", m_axis_tlast, w.last);
      end
      word_count++;
    end
  end

  // receiver stalls in bursts
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (rx_idle && $urandom_range(0, 6) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin
    logic [FW-1:0] phase_files [NUM_PHASES];
    seq_item_t     it;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    err_count     = 0;
    word_count    = 0;
    cycle_count   = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    files_avail   = '0;
    clear_decoder();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIR_ROWS[i].set_max) set_file_count(FILES_MAX);
      send_item(DIR_ROWS[i].item);
      predict_byte(DIR_ROWS[i].item, DIR_ROWS[i].ntyped == 0);
      if (DIR_ROWS[i].ntyped >= 1) pending_words.push_back(DIR_ROWS[i].w0);
      if (DIR_ROWS[i].ntyped >= 2) pending_words.push_back(DIR_ROWS[i].w1);
    end

    phase_files[0] = '0;
    phase_files[1] = 16'd1;
    phase_files[2] = 16'd48;
    phase_files[3] = FILES_MAX;
    phase_files[4] = 16'($urandom);
    phase_files[5] = 16'($urandom_range(2, 600));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_file_count(phase_files[p]);
      // last phase runs flat out on both sides
      tx_idle = (p != NUM_PHASES - 1);
      rx_idle = (p != NUM_PHASES - 1);
      byte_plan.delete();
      while (byte_plan.size() < PHASE_BYTES) plan_sequence();
      while (byte_plan.size() != 0) begin
        it = byte_plan.pop_front();
        send_item(it);
        predict_byte(it, 1'b1);
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
